/* design/rfrc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrc_pkg
// Shared types and constants for the RTU frame receive checker.
// ---------------------------------------------------------------------------
package rfrc_pkg;

    localparam int MAX_FRAME_DEF = 256;

    localparam logic [7:0]  STATION_RESET = 8'h01;
    localparam logic [7:0]  BCAST_ADDR    = 8'hFF;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [8:0]  LEN_SAT       = 9'h1FF;
    localparam int          MIN_FRAME     = 4;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_OTHER_ADR = 2'd1,
        VERDICT_CRC_BAD   = 2'd2,
        VERDICT_SHORT     = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    // packed with verdict in the lowest bits
    typedef struct packed {
        logic [8:0] frame_length;
        logic [7:0] frame_station;
        logic       broadcast;
        verdict_t   verdict;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

/* design/rfrc_in_reg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrc_in_reg
// Input register: holds one received byte until the checker takes it.
// ---------------------------------------------------------------------------
module rfrc_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rfrc_pkg::rx_item_t s_item,
    output logic              item_vld,
    output rfrc_pkg::rx_item_t item,
    input  logic              item_take
);

    logic               vld_reg;
    logic               vld_next;
    rfrc_pkg::rx_item_t item_reg;

    // refill in the same cycle the held item moves on
    assign s_tready = !vld_reg || item_take;
    assign vld_next = (s_tvalid && s_tready) ? 1'b1 : (item_take ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

/* design/rfrc_frame_check.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrc_frame_check
// Running CRC, tail delay, byte count and verdict, with the result register.
// ---------------------------------------------------------------------------
module rfrc_frame_check #(
    parameter int MAX_FRAME = rfrc_pkg::MAX_FRAME_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               item_vld,
    input  rfrc_pkg::rx_item_t item,
    output logic               item_take,
    output logic               res_vld,
    output rfrc_pkg::result_t  res,
    input  logic               res_ready
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int EXT_W = (CNT_W > 10) ? CNT_W : 10;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ rfrc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [7:0]       station_reg;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       tail0_reg;
    logic [7:0]       tail1_reg;
    logic [7:0]       held_reg;
    logic [7:0]       held_next;
    logic [EXT_W-1:0] cnt_ext;
    logic             res_vld_reg;
    logic             res_free;
    logic             end_take;
    rfrc_pkg::result_t res_reg;
    rfrc_pkg::result_t res_next;

    assign res_free  = !res_vld_reg || res_ready;
    // a non-final byte never waits on the result side
    assign item_take = item_vld && (!item.frame_end || res_free);
    assign end_take  = item_take && item.frame_end;

    always_comb begin
        held_next = (cnt_reg == '0) ? item.rx_byte : held_reg;
        crc_next  = (cnt_reg >= CNT_W'(2)) ? crc_feed(crc_reg, tail0_reg) : crc_reg;
        cnt_next  = (cnt_reg < CNT_W'(MAX_FRAME)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        cnt_ext   = EXT_W'(cnt_next);

        res_next.broadcast     = (held_next == rfrc_pkg::BCAST_ADDR);
        res_next.frame_station = held_next;
        res_next.frame_length  = (cnt_ext > EXT_W'(rfrc_pkg::LEN_SAT)) ?
                                 rfrc_pkg::LEN_SAT : cnt_ext[8:0];
        // tail1 is the old tail1 at length-2, the new byte at length-1
        if (cnt_ext < EXT_W'(rfrc_pkg::MIN_FRAME)) begin
            res_next.verdict = rfrc_pkg::VERDICT_SHORT;
        end else if (held_next != rfrc_pkg::BCAST_ADDR && held_next != station_reg) begin
            res_next.verdict = rfrc_pkg::VERDICT_OTHER_ADR;
        end else if (tail1_reg != crc_next[7:0] || item.rx_byte != crc_next[15:8]) begin
            res_next.verdict = rfrc_pkg::VERDICT_CRC_BAD;
        end else begin
            res_next.verdict = rfrc_pkg::VERDICT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg <= rfrc_pkg::STATION_RESET;
        end else if (cfg_we) begin
            station_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= rfrc_pkg::CRC_INIT;
            cnt_reg   <= '0;
            tail0_reg <= '0;
            tail1_reg <= '0;
            held_reg  <= '0;
        end else if (item_take) begin
            if (item.frame_end) begin
                crc_reg   <= rfrc_pkg::CRC_INIT;
                cnt_reg   <= '0;
                tail0_reg <= '0;
                tail1_reg <= '0;
                held_reg  <= '0;
            end else begin
                crc_reg   <= crc_next;
                cnt_reg   <= cnt_next;
                tail0_reg <= tail1_reg;
                tail1_reg <= item.rx_byte;
                held_reg  <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (end_take) begin
            res_vld_reg <= 1'b1;
        end else if (res_ready) begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_take) begin
            res_reg <= res_next;
        end
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

endmodule

/* design/rtu_frame_receive_checker_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtu_frame_receive_checker_core
// Checks RTU frames byte by byte: station address and CRC-16/MODBUS.
// ---------------------------------------------------------------------------
// verdict path: input register, then result register, which drives m_tvalid
// throughput: one byte per cycle unless a last byte waits on a full result
//   register; set by input register, crc/compare stage and result register
// reset: synchronous active-low aresetn clears both valids and frame state,
//   station address returns to 1; no clearing pass
module rtu_frame_receive_checker_core #(
    parameter int MAX_FRAME = rfrc_pkg::MAX_FRAME_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata,   // station_address
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rfrc_pkg::S_TDATA_W-1:0] s_tdata,     // [7:0] rx_byte
    input  logic                           s_tlast,     // frame_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] verdict, [2] broadcast, [10:3] frame_station,
    // [19:11] frame_length, [23:20] zero
    output logic [rfrc_pkg::M_TDATA_W-1:0] m_tdata
);

    rfrc_pkg::rx_item_t s_item;
    rfrc_pkg::rx_item_t item;
    rfrc_pkg::result_t  res;
    logic               item_vld;
    logic               item_take;

    assign s_item.rx_byte   = s_tdata[7:0];
    assign s_item.frame_end = s_tlast;

    rfrc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .item_vld  (item_vld),
        .item      (item),
        .item_take (item_take)
    );

    rfrc_frame_check #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_vld  (item_vld),
        .item      (item),
        .item_take (item_take),
        .res_vld   (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {{(rfrc_pkg::M_TDATA_W - rfrc_pkg::RESULT_W){1'b0}}, res};

endmodule
